// ----- src/atrlc_pkg.sv -----
`default_nettype none
package atrlc_pkg;

  localparam int MAX_RESPONSE_BYTES = 4096;
  localparam int OFFSET_W = 12;
  localparam int OFFSET_CAP_INT = (MAX_RESPONSE_BYTES > 4096) ? 4095 : MAX_RESPONSE_BYTES - 1;
  localparam logic [OFFSET_W-1:0] OFFSET_CAP = OFFSET_W'(OFFSET_CAP_INT);
  localparam logic [OFFSET_W-1:0] LENGTH_MAX = '1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int PAT_COUNT  = 7;
  localparam int PAT_MAXLEN = 11;
  localparam logic [3:0] CODE_START = 4'd11;
  localparam logic [3:0] POS_MAX    = 4'd15;

  // pattern slots
  localparam int PAT_OK        = 0;
  localparam int PAT_ERROR     = 1;
  localparam int PAT_CME       = 2;
  localparam int PAT_CMS       = 3;
  localparam int PAT_PROMPT    = 4;
  localparam int PAT_ECHO_UPPER = 5;
  localparam int PAT_ECHO_LOWER = 6;

  localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_MAXLEN] = '{
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R", ":"},
    '{"+", "C", "M", "S", " ", "E", "R", "R", "O", "R", ":"},
    '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{4'd2, 4'd5, 4'd11, 4'd11, 4'd1, 4'd2, 4'd2};
  localparam logic PAT_EXACT [PAT_COUNT] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  typedef enum logic [2:0] {
    KIND_INFO        = 3'd0,
    KIND_OK          = 3'd1,
    KIND_ERROR       = 3'd2,
    KIND_CME_ERROR   = 3'd3,
    KIND_CMS_ERROR   = 3'd4,
    KIND_PROMPT      = 3'd5,
    KIND_END_NO_STAT = 3'd6
  } line_kind_e;

  typedef enum logic [1:0] {
    CODE_SKIP   = 2'd0,
    CODE_DIGITS = 2'd1,
    CODE_DONE   = 2'd2
  } code_phase_e;

  function automatic logic [7:0] pat_char(input int idx, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 4'(PAT_MAXLEN)) begin
      ch = PAT_TEXT[idx][pos];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- src/at_response_line_classifier_unit.sv -----
`default_nettype none
// Splits a modem AT response, one byte per item, into CR LF terminated lines, trims blanks at
// both ends and reports each kept line as offset and length with its kind (info, OK, ERROR,
// +CME ERROR, +CMS ERROR with parsed code, prompt, or end of response without status). Empty
// lines and a leading command echo give nothing; after a status line bytes are dropped until
// the next byte flagged as first of a response. One byte is taken every cycle: the whole
// per-byte update is one pass of logic between the input register and the result register,
// so a result is registered in the result register when its byte leaves the input register,
// and the input stalls only while the result register is full and not taken.
module at_response_line_classifier_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first_of_response
  input  wire logic        s_axis_tlast_i,   // last_of_response
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [39:0] m_axis_tdata_o,   // [15:0] error_code, [27:16] line_start,
                                             // [39:28] line_length
  output      logic [3:0]  m_axis_tuser_o,   // [2:0] line_kind, [3] response_ok
  output      logic        m_axis_tlast_o    // response_done
);

  localparam int OW = atrlc_pkg::OFFSET_W;
  localparam int PC = atrlc_pkg::PAT_COUNT;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // parser state
  logic                    finished_q, finished_d;
  logic                    awaiting_q, awaiting_d;
  logic [OW-1:0]           offset_q, offset_d;
  logic [OW-1:0]           kept_start_q, kept_start_d;
  logic [OW-1:0]           kept_end_q, kept_end_d;
  logic                    has_content_q, has_content_d;
  logic [3:0]              pat_pos_q, pat_pos_d;
  logic [PC-1:0]           pat_cand_q, pat_cand_d;
  logic                    prev_cr_q, prev_cr_d;
  logic [15:0]             code_acc_q, code_acc_d;
  atrlc_pkg::code_phase_e  code_phase_q, code_phase_d;

  // result register
  logic                    out_valid_q;
  atrlc_pkg::line_kind_e   out_kind_q, out_kind_d;
  logic [15:0]             out_code_q, out_code_d;
  logic [OW-1:0]           out_start_q, out_start_d;
  logic [OW-1:0]           out_length_q, out_length_d;
  logic                    out_ok_q, out_ok_d;
  logic                    out_done_q, out_done_d;

  logic          advance;
  logic          emit;
  logic          blank;
  logic          digit;
  logic          lf_end;
  logic          close_line;
  logic          feed;
  logic [PC-1:0] hit;
  logic          echo;
  logic [OW:0]   length_full;
  logic [19:0]   code_next;
  logic [15:0]   code_sat;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign blank = (in_byte_q == atrlc_pkg::CHAR_SPACE) ||
                 ((in_byte_q >= atrlc_pkg::CHAR_TAB) && (in_byte_q <= atrlc_pkg::CHAR_CR));
  assign digit = (in_byte_q >= atrlc_pkg::CHAR_ZERO) && (in_byte_q <= atrlc_pkg::CHAR_NINE);
  assign code_next = {1'b0, code_acc_q, 3'b000} + {3'b000, code_acc_q, 1'b0} +
                     {16'd0, in_byte_q[3:0]};
  assign code_sat  = (code_next > 20'hFFFF) ? 16'hFFFF : code_next[15:0];

  always_comb begin
    finished_d    = finished_q;
    awaiting_d    = awaiting_q;
    offset_d      = offset_q;
    kept_start_d  = kept_start_q;
    kept_end_d    = kept_end_q;
    has_content_d = has_content_q;
    pat_pos_d     = pat_pos_q;
    pat_cand_d    = pat_cand_q;
    prev_cr_d     = prev_cr_q;
    code_acc_d    = code_acc_q;
    code_phase_d  = code_phase_q;
    lf_end        = 1'b0;
    feed          = 1'b0;
    close_line    = 1'b0;
    emit          = 1'b0;
    echo          = 1'b0;
    hit           = '0;
    length_full   = '0;
    out_kind_d    = atrlc_pkg::KIND_END_NO_STAT;
    out_code_d    = '0;
    out_start_d   = '0;
    out_length_d  = '0;
    out_ok_d      = 1'b0;
    out_done_d    = 1'b0;

    // restart on a first byte
    if (in_first_q) begin
      offset_d      = '0;
      finished_d    = 1'b0;
      awaiting_d    = 1'b1;
      prev_cr_d     = 1'b0;
      kept_start_d  = '0;
      kept_end_d    = '0;
      has_content_d = 1'b0;
      pat_pos_d     = '0;
      pat_cand_d    = '1;
      code_acc_d    = '0;
      code_phase_d  = atrlc_pkg::CODE_SKIP;
    end

    if (!finished_d) begin
      if (prev_cr_d && (in_byte_q == atrlc_pkg::CHAR_LF)) begin
        lf_end    = 1'b1;
        prev_cr_d = 1'b0;
      end else begin
        feed      = has_content_d || !blank;
        prev_cr_d = (in_byte_q == atrlc_pkg::CHAR_CR);
      end

      if (feed) begin
        if (!has_content_d) begin
          has_content_d = 1'b1;
          kept_start_d  = offset_d;
        end
        if (!blank) begin
          kept_end_d = offset_d;
        end
        for (int i = 0; i < PC; i++) begin
          if (pat_pos_d < atrlc_pkg::PAT_LEN[i]) begin
            if (in_byte_q != atrlc_pkg::pat_char(i, pat_pos_d)) begin
              pat_cand_d[i] = 1'b0;
            end
          end else if (atrlc_pkg::PAT_EXACT[i] && !blank) begin
            pat_cand_d[i] = 1'b0;
          end
        end
        // decimal code after the colon of +CME / +CMS
        if (pat_pos_d >= atrlc_pkg::CODE_START) begin
          unique case (code_phase_d)
            atrlc_pkg::CODE_SKIP: begin
              if (digit) begin
                code_acc_d   = {12'd0, in_byte_q[3:0]};
                code_phase_d = atrlc_pkg::CODE_DIGITS;
              end else if (!blank) begin
                code_phase_d = atrlc_pkg::CODE_DONE;
              end
            end
            atrlc_pkg::CODE_DIGITS: begin
              if (digit) begin
                code_acc_d = code_sat;
              end else begin
                code_phase_d = atrlc_pkg::CODE_DONE;
              end
            end
            default: begin
              code_phase_d = code_phase_d;
            end
          endcase
        end
        if (pat_pos_d < atrlc_pkg::POS_MAX) begin
          pat_pos_d = pat_pos_d + 4'd1;
        end
      end

      if (offset_d < atrlc_pkg::OFFSET_CAP) begin
        offset_d = offset_d + OW'(1);
      end

      close_line = lf_end || in_last_q;
    end

    if (close_line) begin
      for (int i = 0; i < PC; i++) begin
        hit[i] = pat_cand_d[i] && (pat_pos_d >= atrlc_pkg::PAT_LEN[i]);
      end
      length_full = {1'b0, kept_end_d} - {1'b0, kept_start_d} + {{OW{1'b0}}, 1'b1};
      out_start_d  = kept_start_d;
      out_length_d = length_full[OW] ? atrlc_pkg::LENGTH_MAX : length_full[OW-1:0];

      if (has_content_d) begin
        echo = awaiting_d && (hit[atrlc_pkg::PAT_ECHO_UPPER] || hit[atrlc_pkg::PAT_ECHO_LOWER]);
        awaiting_d = 1'b0;
      end

      if (has_content_d && !echo) begin
        emit = 1'b1;
        priority if (hit[atrlc_pkg::PAT_OK]) begin
          out_kind_d = atrlc_pkg::KIND_OK;
        end else if (hit[atrlc_pkg::PAT_ERROR]) begin
          out_kind_d = atrlc_pkg::KIND_ERROR;
        end else if (hit[atrlc_pkg::PAT_CME]) begin
          out_kind_d = atrlc_pkg::KIND_CME_ERROR;
          out_code_d = code_acc_d;
        end else if (hit[atrlc_pkg::PAT_CMS]) begin
          out_kind_d = atrlc_pkg::KIND_CMS_ERROR;
          out_code_d = code_acc_d;
        end else if (hit[atrlc_pkg::PAT_PROMPT]) begin
          out_kind_d = atrlc_pkg::KIND_PROMPT;
        end else begin
          out_kind_d = atrlc_pkg::KIND_INFO;
        end
        out_ok_d   = (out_kind_d == atrlc_pkg::KIND_OK) ||
                     (out_kind_d == atrlc_pkg::KIND_PROMPT);
        out_done_d = (out_kind_d != atrlc_pkg::KIND_INFO) || in_last_q;
        finished_d = out_done_d;
      end else if (in_last_q) begin
        // empty line or echo at the end of the response
        emit         = 1'b1;
        out_kind_d   = atrlc_pkg::KIND_END_NO_STAT;
        out_start_d  = '0;
        out_length_d = '0;
        out_done_d   = 1'b1;
        finished_d   = 1'b1;
      end

      kept_start_d  = '0;
      kept_end_d    = '0;
      has_content_d = 1'b0;
      pat_pos_d     = '0;
      pat_cand_d    = '1;
      code_acc_d    = '0;
      code_phase_d  = atrlc_pkg::CODE_SKIP;
      prev_cr_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      finished_q    <= 1'b1;
      awaiting_q    <= 1'b1;
      offset_q      <= '0;
      kept_start_q  <= '0;
      kept_end_q    <= '0;
      has_content_q <= 1'b0;
      pat_pos_q     <= '0;
      pat_cand_q    <= '1;
      prev_cr_q     <= 1'b0;
      code_acc_q    <= '0;
      code_phase_q  <= atrlc_pkg::CODE_SKIP;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && emit;
      end
      if (in_valid_q && advance) begin
        finished_q    <= finished_d;
        awaiting_q    <= awaiting_d;
        offset_q      <= offset_d;
        kept_start_q  <= kept_start_d;
        kept_end_q    <= kept_end_d;
        has_content_q <= has_content_d;
        pat_pos_q     <= pat_pos_d;
        pat_cand_q    <= pat_cand_d;
        prev_cr_q     <= prev_cr_d;
        code_acc_q    <= code_acc_d;
        code_phase_q  <= code_phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
    if (in_valid_q && advance && emit) begin
      out_kind_q   <= out_kind_d;
      out_code_q   <= out_code_d;
      out_start_q  <= out_start_d;
      out_length_q <= out_length_d;
      out_ok_q     <= out_ok_d;
      out_done_q   <= out_done_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_length_q, out_start_q, out_code_q};
  assign m_axis_tuser_o  = {out_ok_q, out_kind_q};
  assign m_axis_tlast_o  = out_done_q;

endmodule
`default_nettype wire
